[src/bslp_pkg.sv]
// ----------------------------------------------------------------------------
// Button press detector package
// Shared types and state codes for the debounced short/long press detector.
// ----------------------------------------------------------------------------
package bslp_pkg;

    localparam int unsigned TimeWidth  = 16;
    localparam int unsigned CfgWidth   = 15;
    localparam int unsigned StateWidth = 3;

    localparam logic [CfgWidth-1:0] DebounceReset  = 15'd50;
    localparam logic [CfgWidth-1:0] LongPressReset = 15'd1000;

    // Register indexes on the configuration port.
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    typedef enum logic [StateWidth-1:0] {
        ST_IDLE     = 3'd0,
        ST_PRESS_DB = 3'd1,
        ST_PRESSED  = 3'd2,
        ST_REL_DB   = 3'd3,
        ST_LONG     = 3'd4,
        ST_LONG_DB  = 3'd5
    } press_state_t;

    typedef struct packed {
        logic [CfgWidth-1:0] debounce_ms;
        logic [CfgWidth-1:0] long_press_ms;
    } cfg_t;

    typedef struct packed {
        logic                 ack_pending;
        logic                 ack_long;
        logic                 ack_short;
        logic [TimeWidth-1:0] now_ms;
        logic                 button_level;
    } item_t;

    typedef struct packed {
        press_state_t press_state;
        logic         release_pending;
        logic         long_press;
        logic         short_press;
    } result_t;

endpackage

[src/bslp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the debounce and long-press times.
// ----------------------------------------------------------------------------
module bslp_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output bslp_pkg::cfg_t   cfg
);
    import bslp_pkg::*;

    logic [CfgWidth-1:0] debounce_reg;
    logic [CfgWidth-1:0] long_press_reg;
    logic                wr_en;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DebounceReset;
            long_press_reg <= LongPressReset;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_DEBOUNCE:   debounce_reg   <= pwdata[CfgWidth-1:0];
                REG_LONG_PRESS: long_press_reg <= pwdata[CfgWidth-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_DEBOUNCE:   prdata = {{(32-CfgWidth){1'b0}}, debounce_reg};
            REG_LONG_PRESS: prdata = {{(32-CfgWidth){1'b0}}, long_press_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.debounce_ms   = debounce_reg;
    assign cfg.long_press_ms = long_press_reg;

endmodule

[src/bslp_fsm.sv]
// ----------------------------------------------------------------------------
// Press state machine
// Holds the debounce state, deadline and sticky flags, and computes one step.
// ----------------------------------------------------------------------------
module bslp_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  bslp_pkg::item_t   item,
    input  bslp_pkg::cfg_t    cfg,
    output bslp_pkg::result_t result
);
    import bslp_pkg::*;

    press_state_t         state_reg, state_next;
    logic [TimeWidth-1:0] deadline_reg, deadline_next;
    logic                 short_reg, short_next;
    logic                 long_reg, long_next;
    logic                 pending_reg, pending_next;

    logic                 pressed;
    logic                 reached;
    logic [TimeWidth-1:0] diff;
    logic [TimeWidth-1:0] short_deadline;
    logic [TimeWidth-1:0] long_deadline;

    assign pressed        = ~item.button_level;
    assign diff           = item.now_ms - deadline_reg;
    // The deadline counts as reached once the wrapped difference is not negative.
    assign reached        = ~diff[TimeWidth-1];
    assign short_deadline = item.now_ms + {1'b0, cfg.debounce_ms};
    assign long_deadline  = item.now_ms + {1'b0, cfg.long_press_ms}
                            - {1'b0, cfg.debounce_ms};

    always_comb
    begin
        state_next    = state_reg;
        deadline_next = deadline_reg;
        short_next    = short_reg & ~item.ack_short;
        long_next     = long_reg & ~item.ack_long;
        pending_next  = pending_reg & ~item.ack_pending;

        case (state_reg)
            ST_IDLE:
            begin
                if (pressed)
                begin
                    state_next    = ST_PRESS_DB;
                    deadline_next = short_deadline;
                end
            end
            ST_PRESS_DB:
            begin
                if (!pressed)
                begin
                    state_next = ST_IDLE;
                end
                else if (reached)
                begin
                    state_next    = ST_PRESSED;
                    deadline_next = long_deadline;
                end
            end
            ST_PRESSED:
            begin
                if (reached)
                begin
                    state_next   = ST_LONG;
                    long_next    = 1'b1;
                    pending_next = 1'b1;
                end
                else if (!pressed)
                begin
                    state_next    = ST_REL_DB;
                    deadline_next = short_deadline;
                end
            end
            ST_REL_DB:
            begin
                if (pressed)
                begin
                    state_next    = ST_PRESSED;
                    deadline_next = long_deadline;
                end
                else if (reached)
                begin
                    state_next = ST_IDLE;
                    short_next = 1'b1;
                end
            end
            ST_LONG:
            begin
                pending_next = 1'b1;
                if (!pressed)
                begin
                    state_next    = ST_LONG_DB;
                    deadline_next = short_deadline;
                end
            end
            ST_LONG_DB:
            begin
                if (pressed)
                begin
                    state_next   = ST_LONG;
                    pending_next = 1'b1;
                end
                else if (reached)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pending_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            deadline_reg <= '0;
            short_reg    <= 1'b0;
            long_reg     <= 1'b0;
            pending_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            state_reg    <= state_next;
            deadline_reg <= deadline_next;
            short_reg    <= short_next;
            long_reg     <= long_next;
            pending_reg  <= pending_next;
        end
    end

    assign result.press_state     = state_next;
    assign result.release_pending = pending_next;
    assign result.long_press      = long_next;
    assign result.short_press     = short_next;

endmodule

[src/button_short_long_press_detector_core.sv]
// ----------------------------------------------------------------------------
// Button short/long press detector
// Debounces an active-low button sampled once per word and reports sticky
// short-press, long-press and release-pending flags with the machine state.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock while it is not stalled by the
// output side and returns one result word for each. A word is held in an
// input register, stepped through the press state machine, and the result
// lands in an output register. The state machine update is the only loop.
// Configuration writes are meant for times when no word is in flight.
module button_short_long_press_detector_core (
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] button_level, [16:1] now_ms, [17] ack_short, [18] ack_long,
    // [19] ack_pending, [23:20] zero
    input  logic [23:0] s_tdata,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] short_press, [1] long_press, [2] release_pending,
    // [5:3] press_state, [7:6] zero
    output logic [7:0]  m_tdata
);
    import bslp_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    step_en;
    logic    s_fire;

    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    bslp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bslp_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg <= s_tdata[19:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result_reg};

endmodule
